FILE: src/ptfs_pkg.sv
package ptfs_pkg;

    // Field and register widths
    localparam int POS_W      = 11;
    localparam int IN_W       = 32;
    localparam int NODE_W     = 33;
    localparam int CNT_W      = 11;
    localparam int MODE_W     = 2;
    localparam int GRID_W     = 2;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = 36;
    localparam int PROD_W       = 53;
    localparam int SUM_W        = 70;
    localparam int SHIFT_PLAIN  = 17;
    localparam int SHIFT_SMOOTH = 19;

    // Parameter defaults and limits
    localparam int MAX_CELLS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MIN_CELLS      = 3;

    // Function codes of an input word
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Edge modes
    localparam logic [MODE_W-1:0] EDGE_ZERO     = 2'd0;
    localparam logic [MODE_W-1:0] EDGE_REFLECT  = 2'd1;
    localparam logic [MODE_W-1:0] EDGE_PERIODIC = 2'd2;

    // Grid kinds
    localparam logic [GRID_W-1:0] GRID_UNIFORM = 2'd0;
    localparam logic [GRID_W-1:0] GRID_CELL    = 2'd1;
    localparam logic [GRID_W-1:0] GRID_NONE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EDGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_KIND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_SCALE = 3'd5;

    // Reset values
    localparam logic [CNT_W-1:0]   CELL_COUNT_RESET = 11'd1024;
    localparam logic [SCALE_W-1:0] UNIT_SCALE       = 32'd65536;

    // Node fetch slots, relative to the requested cell p
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = 3;
    localparam logic [SLOT_W-1:0] SLOT_PREV  = 3'd0;  // p-1
    localparam logic [SLOT_W-1:0] SLOT_HERE  = 3'd1;  // p
    localparam logic [SLOT_W-1:0] SLOT_NEXT  = 3'd2;  // p+1
    localparam logic [SLOT_W-1:0] SLOT_NEXT2 = 3'd3;  // p+2
    localparam logic [SLOT_W-1:0] SLOT_WRAPA = 3'd4;  // far edge, first node
    localparam logic [SLOT_W-1:0] SLOT_WRAPB = 3'd5;  // far edge, second node

    typedef logic signed [2:0] coef_t;
    typedef coef_t [NUM_SLOTS-1:0] coef_set_t;

    typedef struct packed {
        logic  node_we;
        logic  scale_we;
        logic  node_rd;
        logic  scale_rd;
        logic  acc_clear;
        coef_t coef;
        logic  mul;
        logic  sum;
        logic  out_load;
        logic  out_zero;
    } cmd_t;

    // Weights of the node sums that make up the numerator of one cell
    function automatic coef_set_t slot_coefs(
        input logic              smooth,
        input logic              at_left,
        input logic              at_right,
        input logic [MODE_W-1:0] left_mode,
        input logic [MODE_W-1:0] right_mode
    );
        coef_set_t c;
        c = '0;
        if (!smooth) begin
            c[SLOT_HERE] = 3'sd1;
            c[SLOT_NEXT] = -3'sd1;
        end else if (at_left) begin
            case (left_mode)
                EDGE_ZERO: begin
                    c[SLOT_HERE]  = 3'sd3;
                    c[SLOT_NEXT]  = -3'sd2;
                    c[SLOT_NEXT2] = -3'sd1;
                end
                EDGE_REFLECT: begin
                    c[SLOT_HERE]  = 3'sd1;
                    c[SLOT_NEXT2] = -3'sd1;
                end
                default: begin
                    c[SLOT_HERE]  = 3'sd2;
                    c[SLOT_NEXT]  = -3'sd1;
                    c[SLOT_NEXT2] = -3'sd1;
                    c[SLOT_WRAPA] = 3'sd1;
                    c[SLOT_WRAPB] = -3'sd1;
                end
            endcase
        end else if (at_right) begin
            case (right_mode)
                EDGE_ZERO: begin
                    c[SLOT_PREV] = 3'sd1;
                    c[SLOT_HERE] = 3'sd2;
                    c[SLOT_NEXT] = -3'sd3;
                end
                EDGE_REFLECT: begin
                    c[SLOT_PREV] = 3'sd1;
                    c[SLOT_NEXT] = -3'sd1;
                end
                default: begin
                    c[SLOT_PREV]  = 3'sd1;
                    c[SLOT_HERE]  = 3'sd1;
                    c[SLOT_NEXT]  = -3'sd2;
                    c[SLOT_WRAPA] = 3'sd1;
                    c[SLOT_WRAPB] = -3'sd1;
                end
            endcase
        end else begin
            c[SLOT_PREV]  = 3'sd1;
            c[SLOT_HERE]  = 3'sd1;
            c[SLOT_NEXT]  = -3'sd1;
            c[SLOT_NEXT2] = -3'sd1;
        end
        return c;
    endfunction

endpackage

FILE: src/potential_to_field_with_smoothing.sv
// Channel   Handshake          Word
// s_        s_valid/s_ready    s_func, s_position, s_potential_now,
//                              s_potential_before, s_cell_inverse_width
// m_        m_valid/m_ready    m_field_value, m_saturated
// cfg_      cfg_we             cfg_index, cfg_wdata (no wait, no read-back)
//
// A load word is written as it is accepted. A read steps through the fetch,
// drain, multiply, sum and done states before the next word is taken; fetch
// reads the 2 to 5 node sums that the cell needs, and the single-port node
// memory delivers one sum per cycle. A read beyond the cell count skips to
// done and returns zero. aresetn is synchronous and active low; the memories
// are not cleared. The result sits in an output register: loads and a read's
// steps run while an earlier result waits on m_ready, up to the done state.
module potential_to_field_with_smoothing #(
    parameter int MAX_CELLS  = ptfs_pkg::MAX_CELLS_DEF,
    parameter int VALUE_BITS = ptfs_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [ptfs_pkg::POS_W-1:0]          s_position,
    input  logic signed [ptfs_pkg::IN_W-1:0]    s_potential_now,
    input  logic signed [ptfs_pkg::IN_W-1:0]    s_potential_before,
    input  logic [ptfs_pkg::SCALE_W-1:0]        s_cell_inverse_width,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_BITS-1:0]        m_field_value,
    output logic                                m_saturated,
    input  logic                                cfg_we,
    input  logic [ptfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ptfs_pkg::*;

    localparam int NAW = $clog2(MAX_CELLS + 1);
    localparam int SAW = $clog2(MAX_CELLS);

    logic [CNT_W-1:0]   cell_count_reg;
    logic               smoothing_reg;
    logic [MODE_W-1:0]  left_mode_reg;
    logic [MODE_W-1:0]  right_mode_reg;
    logic [GRID_W-1:0]  grid_kind_reg;
    logic [SCALE_W-1:0] uniform_scale_reg;

    cmd_t               cmd;
    logic [NAW-1:0]     node_addr;
    logic [SAW-1:0]     scale_addr;
    logic               out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg    <= CELL_COUNT_RESET;
            smoothing_reg     <= 1'b0;
            left_mode_reg     <= EDGE_ZERO;
            right_mode_reg    <= EDGE_ZERO;
            grid_kind_reg     <= GRID_UNIFORM;
            uniform_scale_reg <= UNIT_SCALE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CELL_COUNT:    cell_count_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_SMOOTHING:     smoothing_reg     <= cfg_wdata[0];
                CFG_LEFT_EDGE:     left_mode_reg     <= cfg_wdata[MODE_W-1:0];
                CFG_RIGHT_EDGE:    right_mode_reg    <= cfg_wdata[MODE_W-1:0];
                CFG_GRID_KIND:     grid_kind_reg     <= cfg_wdata[GRID_W-1:0];
                CFG_UNIFORM_SCALE: uniform_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    ptfs_ctrl #(
        .MAX_CELLS(MAX_CELLS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_position       (s_position),
        .cell_count       (cell_count_reg),
        .smoothing_enable (smoothing_reg),
        .left_edge_mode   (left_mode_reg),
        .right_edge_mode  (right_mode_reg),
        .out_free         (out_free),
        .cmd              (cmd),
        .node_addr        (node_addr),
        .scale_addr       (scale_addr)
    );

    ptfs_dpath #(
        .MAX_CELLS  (MAX_CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .node_addr             (node_addr),
        .scale_addr            (scale_addr),
        .potential_now         (s_potential_now),
        .potential_before      (s_potential_before),
        .cell_inverse_width    (s_cell_inverse_width),
        .smoothing_enable      (smoothing_reg),
        .grid_kind             (grid_kind_reg),
        .uniform_inverse_width (uniform_scale_reg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_field_value         (m_field_value),
        .m_saturated           (m_saturated),
        .out_free              (out_free)
    );

endmodule

FILE: src/ptfs_ctrl.sv
module ptfs_ctrl #(
    parameter int MAX_CELLS = ptfs_pkg::MAX_CELLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [ptfs_pkg::POS_W-1:0]      s_position,
    input  logic [ptfs_pkg::CNT_W-1:0]      cell_count,
    input  logic                            smoothing_enable,
    input  logic [ptfs_pkg::MODE_W-1:0]     left_edge_mode,
    input  logic [ptfs_pkg::MODE_W-1:0]     right_edge_mode,
    input  logic                            out_free,
    output ptfs_pkg::cmd_t                  cmd,
    output logic [$clog2(MAX_CELLS+1)-1:0]  node_addr,
    output logic [$clog2(MAX_CELLS)-1:0]    scale_addr
);
    import ptfs_pkg::*;

    localparam int NAW    = $clog2(MAX_CELLS + 1);
    localparam int SAW    = $clog2(MAX_CELLS);
    localparam int ADDR_W = POS_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 left_reg, left_next;
    logic                 zero_reg, zero_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    coef_set_t            coefs_reg, coefs_next;

    logic [CNT_W-1:0]     n_eff;
    logic                 at_left, at_right, out_of_range;
    coef_set_t            coefs_new;
    logic [NUM_SLOTS-1:0] mask_new;
    logic [SLOT_W-1:0]    slot;
    logic                 found;
    logic [ADDR_W-1:0]    pos_ext, n_ext, slot_addr;

    // Clamp the cell count into the usable range
    always_comb begin
        if (cell_count < CNT_W'(MIN_CELLS)) begin
            n_eff = CNT_W'(MIN_CELLS);
        end else if (32'(cell_count) > 32'(MAX_CELLS)) begin
            n_eff = CNT_W'(MAX_CELLS);
        end else begin
            n_eff = cell_count;
        end
    end

    assign out_of_range = s_position >= n_eff;
    assign at_left      = s_position == '0;
    assign at_right     = s_position == (n_eff - CNT_W'(1));

    always_comb begin
        coefs_new = slot_coefs(smoothing_enable, at_left, at_right,
                               left_edge_mode, right_edge_mode);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            mask_new[i] = coefs_new[i] != '0;
        end
    end

    // Lowest slot still to fetch
    always_comb begin
        slot  = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && mask_reg[i]) begin
                slot  = SLOT_W'(i);
                found = 1'b1;
            end
        end
    end

    assign pos_ext = {1'b0, pos_reg};
    assign n_ext   = {1'b0, n_reg};

    always_comb begin
        case (slot)
            SLOT_PREV:  slot_addr = pos_ext - ADDR_W'(1);
            SLOT_HERE:  slot_addr = pos_ext;
            SLOT_NEXT:  slot_addr = pos_ext + ADDR_W'(1);
            SLOT_NEXT2: slot_addr = pos_ext + ADDR_W'(2);
            SLOT_WRAPA: slot_addr = left_reg ? n_ext - ADDR_W'(1) : ADDR_W'(0);
            SLOT_WRAPB: slot_addr = left_reg ? n_ext : ADDR_W'(1);
            default:    slot_addr = pos_ext;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        left_next  = left_reg;
        zero_next  = zero_reg;
        mask_next  = mask_reg;
        coefs_next = coefs_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        node_addr  = NAW'(slot_addr);
        scale_addr = SAW'(pos_reg);
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                node_addr  = NAW'(s_position);
                scale_addr = SAW'(s_position);
                if (s_valid) begin
                    if (s_func == FUNC_LOAD) begin
                        // drop what falls outside the stores
                        cmd.node_we  = 32'(s_position) <= 32'(MAX_CELLS);
                        cmd.scale_we = 32'(s_position) < 32'(MAX_CELLS);
                    end else begin
                        pos_next      = s_position;
                        n_next        = n_eff;
                        left_next     = at_left;
                        zero_next     = out_of_range;
                        coefs_next    = coefs_new;
                        mask_next     = mask_new;
                        cmd.acc_clear = 1'b1;
                        state_next    = out_of_range ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.node_rd  = 1'b1;
                cmd.scale_rd = 1'b1;
                cmd.coef     = coefs_reg[slot];
                mask_next    = mask_reg & ~(NUM_SLOTS'(1) << slot);
                if (mask_next == '0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the word
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = zero_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        n_reg     <= n_next;
        left_reg  <= left_next;
        coefs_reg <= coefs_next;
    end

endmodule

FILE: src/ptfs_dpath.sv
module ptfs_dpath #(
    parameter int MAX_CELLS  = ptfs_pkg::MAX_CELLS_DEF,
    parameter int VALUE_BITS = ptfs_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ptfs_pkg::cmd_t                      cmd,
    input  logic [$clog2(MAX_CELLS+1)-1:0]      node_addr,
    input  logic [$clog2(MAX_CELLS)-1:0]        scale_addr,
    input  logic signed [ptfs_pkg::IN_W-1:0]    potential_now,
    input  logic signed [ptfs_pkg::IN_W-1:0]    potential_before,
    input  logic [ptfs_pkg::SCALE_W-1:0]        cell_inverse_width,
    input  logic                                smoothing_enable,
    input  logic [ptfs_pkg::GRID_W-1:0]         grid_kind,
    input  logic [ptfs_pkg::SCALE_W-1:0]        uniform_inverse_width,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_BITS-1:0]        m_field_value,
    output logic                                m_saturated,
    output logic                                out_free
);
    import ptfs_pkg::*;

    localparam int HALF_W = SCALE_W / 2;

    logic signed [NODE_W-1:0] node_mem [0:MAX_CELLS];
    logic [SCALE_W-1:0]       scale_mem [0:MAX_CELLS-1];

    logic signed [NODE_W-1:0] node_wdata;
    logic signed [NODE_W-1:0] node_rd_reg;
    logic [SCALE_W-1:0]       scale_rd_reg;
    logic                     pend_reg;
    coef_t                    coef_d_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_hi_reg, prod_lo_reg;
    logic signed [SUM_W-1:0]  val_reg;

    logic                     m_valid_reg;
    logic signed [VALUE_BITS-1:0] field_reg;
    logic                     sat_reg;

    coef_t                    neg_coef;
    logic [1:0]               coef_mag;
    logic signed [ACC_W-1:0]  term_base, term;
    logic [SCALE_W-1:0]       scale_sel;
    logic signed [HALF_W:0]   scale_hi, scale_lo;
    logic signed [SUM_W-1:0]  hi_ext, lo_ext, round_add, t_sum, t_shifted;
    logic [SUM_W-VALUE_BITS:0] upper;
    logic                     sat_pos, sat_neg;
    logic signed [VALUE_BITS-1:0] field_sat;

    assign node_wdata = NODE_W'(potential_now) + NODE_W'(potential_before);

    always_ff @(posedge aclk) begin
        if (cmd.node_we) begin
            node_mem[node_addr] <= node_wdata;
        end
        if (cmd.node_rd) begin
            node_rd_reg <= node_mem[node_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scale_we) begin
            scale_mem[scale_addr] <= cell_inverse_width;
        end
        if (cmd.scale_rd) begin
            scale_rd_reg <= scale_mem[scale_addr];
        end
    end

    // Weight the fetched node sum by -3..3 with shift and add
    always_comb begin
        neg_coef  = -coef_d_reg;
        coef_mag  = coef_d_reg[2] ? neg_coef[1:0] : coef_d_reg[1:0];
        term_base = ACC_W'(node_rd_reg);
        case (coef_mag)
            2'd1:    term = term_base;
            2'd2:    term = term_base <<< 1;
            2'd3:    term = term_base + (term_base <<< 1);
            default: term = '0;
        endcase
        if (cmd.acc_clear) begin
            acc_next = '0;
        end else if (pend_reg) begin
            acc_next = coef_d_reg[2] ? acc_reg - term : acc_reg + term;
        end else begin
            acc_next = acc_reg;
        end
    end

    always_comb begin
        case (grid_kind)
            GRID_UNIFORM: scale_sel = uniform_inverse_width;
            GRID_CELL:    scale_sel = scale_rd_reg;
            default:      scale_sel = UNIT_SCALE;
        endcase
        scale_hi = $signed({1'b0, scale_sel[SCALE_W-1:HALF_W]});
        scale_lo = $signed({1'b0, scale_sel[HALF_W-1:0]});
    end

    // Round half up once, then drop the fraction and the filter weight
    always_comb begin
        hi_ext    = SUM_W'(prod_hi_reg);
        lo_ext    = SUM_W'(prod_lo_reg);
        round_add = smoothing_enable ? SUM_W'(1) <<< (SHIFT_SMOOTH - 1)
                                     : SUM_W'(1) <<< (SHIFT_PLAIN - 1);
        t_sum     = (hi_ext <<< FRAC_BITS) + lo_ext + round_add;
        t_shifted = smoothing_enable ? t_sum >>> SHIFT_SMOOTH : t_sum >>> SHIFT_PLAIN;
    end

    // Clip to the signed output range
    always_comb begin
        upper   = val_reg[SUM_W-1:VALUE_BITS-1];
        sat_pos = !val_reg[SUM_W-1] && (|upper);
        sat_neg = val_reg[SUM_W-1] && !(&upper);
        if (sat_pos) begin
            field_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else if (sat_neg) begin
            field_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            field_sat = val_reg[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.node_rd;
        end
    end

    always_ff @(posedge aclk) begin
        coef_d_reg <= cmd.coef;
        acc_reg    <= acc_next;
        if (cmd.mul) begin
            prod_hi_reg <= PROD_W'(acc_reg * scale_hi);
            prod_lo_reg <= PROD_W'(acc_reg * scale_lo);
        end
        if (cmd.sum) begin
            val_reg <= t_shifted;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            field_reg <= cmd.out_zero ? '0 : field_sat;
            sat_reg   <= cmd.out_zero ? 1'b0 : (sat_pos || sat_neg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_field_value = field_reg;
    assign m_saturated   = sat_reg;

endmodule

FILE: dv/testbench.sv
module testbench;
    import ptfs_pkg::*;

    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int CELLS       = MAX_CELLS_DEF;
    localparam int IDLE_WAIT   = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int TOP_POS     = (1 << POS_W) - 1;

    // Spare codes: the block treats them as periodic and as no scaling
    localparam logic [MODE_W-1:0] EDGE_ALT_WRAP = 2'd3;
    localparam logic [GRID_W-1:0] GRID_ALT_NONE = 2'd3;

    localparam longint FIELD_MAX = (longint'(1) << (VBITS - 1)) - 1;
    localparam longint FIELD_MIN = -FIELD_MAX - 1;

    typedef struct packed {
        logic               func;
        logic [POS_W-1:0]   pos;
        logic [IN_W-1:0]    phi_now;
        logic [IN_W-1:0]    phi_prev;
        logic [SCALE_W-1:0] inv_width;
    } word_t;

    typedef struct packed {
        logic signed [VBITS-1:0] value;
        logic                    clipped;
    } field_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    word_t                   cur_word  = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic signed [VBITS-1:0] m_field_value;
    logic                    m_saturated;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    hold_off  = 1'b0;

    // Register copies used for prediction and stimulus shaping
    logic [CNT_W-1:0]   reg_cells  = CELL_COUNT_RESET;
    logic               reg_smooth = 1'b0;
    logic [MODE_W-1:0]  reg_left   = EDGE_ZERO;
    logic [MODE_W-1:0]  reg_right  = EDGE_ZERO;
    logic [GRID_W-1:0]  reg_grid   = GRID_UNIFORM;
    logic [SCALE_W-1:0] reg_uscale = UNIT_SCALE;

    longint             node_sum   [0:CELLS];
    logic [SCALE_W-1:0] cell_scale [0:CELLS-1];
    bit                 loaded     [0:CELLS];

    word_t  outgoing[$];
    field_t fields_due[$];
    word_t  next_word;
    field_t want;

    int errors         = 0;
    int words_pushed   = 0;
    int words_taken    = 0;
    int loads_seen     = 0;
    int reads_seen     = 0;
    int beyond_seen    = 0;
    int clipped_seen   = 0;
    int settings_used  = 0;
    int phase_no       = -1;
    int burst_left     = 0;
    int gap_left       = 0;
    logic [15:0] rx_cycle = '0;

    potential_to_field_with_smoothing dut (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_func              (cur_word.func),
        .s_position          (cur_word.pos),
        .s_potential_now     (cur_word.phi_now),
        .s_potential_before  (cur_word.phi_prev),
        .s_cell_inverse_width(cur_word.inv_width),
        .m_valid,
        .m_ready,
        .m_field_value,
        .m_saturated,
        .cfg_we,
        .cfg_index,
        .cfg_wdata
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int active_cells();
        if (reg_cells < MIN_CELLS) return MIN_CELLS;
        if (reg_cells > CELLS) return CELLS;
        return int'(reg_cells);
    endfunction

    function automatic longint slope(int j);
        return node_sum[j] - node_sum[j + 1];
    endfunction

    function automatic longint edge_sum(logic [MODE_W-1:0] mode, longint edge_d,
                                        longint inner_d, longint opp_d);
        if (mode == EDGE_ZERO) return 3 * edge_d + inner_d;
        if (mode == EDGE_REFLECT) return edge_d + inner_d;
        return 2 * edge_d + inner_d + opp_d;
    endfunction

    function automatic field_t cell_field(int pos);
        field_t             f;
        int                 n;
        int                 k;
        longint             num;
        longint             hi;
        longint             lo;
        longint             t;
        longint             v;
        logic [SCALE_W-1:0] scale;
        f = '0;
        n = active_cells();
        if (pos >= n) return f;
        if (!reg_smooth) begin
            k   = 1;
            num = slope(pos);
        end else begin
            k = 3;
            if (pos == 0)
                num = edge_sum(reg_left, slope(0), slope(1), slope(n - 1));
            else if (pos == n - 1)
                num = edge_sum(reg_right, slope(n - 1), slope(n - 2), slope(0));
            else
                num = slope(pos - 1) + 2 * slope(pos) + slope(pos + 1);
        end
        case (reg_grid)
            GRID_UNIFORM: scale = reg_uscale;
            GRID_CELL:    scale = cell_scale[pos];
            default:      scale = UNIT_SCALE;
        endcase
        // split the Q16.16 scale so the product stays within 64 bits, round once
        hi = longint'(scale[SCALE_W-1:FRAC_BITS]);
        lo = longint'(scale[FRAC_BITS-1:0]);
        t  = num * hi + ((num * lo + (longint'(1) << (FRAC_BITS - 1 + k))) >>> FRAC_BITS);
        v  = t >>> k;
        if (v > FIELD_MAX) begin
            v         = FIELD_MAX;
            f.clipped = 1'b1;
        end else if (v < FIELD_MIN) begin
            v         = FIELD_MIN;
            f.clipped = 1'b1;
        end
        f.value = v[VBITS-1:0];
        return f;
    endfunction

    function automatic void apply_word(word_t w);
        field_t f;
        int     p;
        p = int'(w.pos);
        words_taken++;
        if (w.func == FUNC_LOAD) begin
            loads_seen++;
            if (p <= CELLS)
                node_sum[p] = longint'($signed(w.phi_now)) + longint'($signed(w.phi_prev));
            if (p < CELLS)
                cell_scale[p] = w.inv_width;
        end else begin
            reads_seen++;
            if (p >= active_cells()) beyond_seen++;
            f = cell_field(p);
            if (f.clipped) clipped_seen++;
            fields_due.push_back(f);
        end
    endfunction

    function automatic logic [IN_W-1:0] rand_potential();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2, 3: return $urandom_range(0, 32'h1FFFF) - 32'h10000;
            4:    return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFFFFFF;
                    1:       return 32'h80000000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(0, 32'hFFFF);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] rand_inv_width();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(32'h8000, 32'h30000);
            2: return $urandom_range(0, 32'hFFFF);
            3: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return UNIT_SCALE;
                endcase
            end
            default: return $urandom_range(32'h10000, 32'h400000);
        endcase
    endfunction

    function automatic void push_load(int pos, logic [IN_W-1:0] phi_now,
                                      logic [IN_W-1:0] phi_prev, logic [SCALE_W-1:0] inv_w);
        word_t w;
        w.func      = FUNC_LOAD;
        w.pos       = pos[POS_W-1:0];
        w.phi_now   = phi_now;
        w.phi_prev  = phi_prev;
        w.inv_width = inv_w;
        outgoing.push_back(w);
        words_pushed++;
        if (pos <= CELLS) loaded[pos] = 1'b1;
    endfunction

    function automatic void push_random_load(int pos);
        push_load(pos, rand_potential(), rand_potential(), rand_inv_width());
    endfunction

    function automatic void ensure_node(int j);
        if (!loaded[j]) push_random_load(j);
    endfunction

    // Load every node and scale the cell touches before reading it
    function automatic void push_read(int pos);
        word_t w;
        int    n;
        int    lo_node;
        int    hi_node;
        n = active_cells();
        if (pos < n) begin
            if (!reg_smooth) begin
                lo_node = pos;
                hi_node = pos + 1;
            end else if (pos == 0) begin
                lo_node = 0;
                hi_node = 2;
            end else if (pos == n - 1) begin
                lo_node = n - 2;
                hi_node = n;
            end else begin
                lo_node = pos - 1;
                hi_node = pos + 2;
            end
            for (int j = lo_node; j <= hi_node; j++) ensure_node(j);
            if (reg_smooth && pos == 0 && reg_left != EDGE_ZERO && reg_left != EDGE_REFLECT) begin
                ensure_node(n - 1);
                ensure_node(n);
            end
            if (reg_smooth && pos == n - 1 && reg_right != EDGE_ZERO
                    && reg_right != EDGE_REFLECT) begin
                ensure_node(0);
                ensure_node(1);
            end
        end
        w.func      = FUNC_READ;
        w.pos       = pos[POS_W-1:0];
        w.phi_now   = rand_potential();
        w.phi_prev  = rand_potential();
        w.inv_width = rand_inv_width();
        outgoing.push_back(w);
        words_pushed++;
    endfunction

    function automatic void random_phase(int count);
        int n;
        int pick;
        int pos;
        n = active_cells();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                case ($urandom_range(0, 3))
                    0:       pos = 0;
                    1:       pos = n - 1;
                    default: pos = $urandom_range(0, n - 1);
                endcase
                push_read(pos);
            end else if (pick < 16) begin
                push_random_load($urandom_range(0, n));
            end else if (pick < 18) begin
                push_read($urandom_range(n, TOP_POS));
            end else begin
                push_random_load($urandom_range(0, TOP_POS));
            end
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int width,
                                                        bit noisy);
        if (!noisy) return v;
        return ((CFG_DATA_W'($urandom) >> width) << width) | v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_CELL_COUNT:    reg_cells  = data[CNT_W-1:0];
            CFG_SMOOTHING:     reg_smooth = data[0];
            CFG_LEFT_EDGE:     reg_left   = data[MODE_W-1:0];
            CFG_RIGHT_EDGE:    reg_right  = data[MODE_W-1:0];
            CFG_GRID_KIND:     reg_grid   = data[GRID_W-1:0];
            CFG_UNIFORM_SCALE: reg_uscale = data[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_registers(int cells, bit smooth, logic [MODE_W-1:0] left_m,
                                 logic [MODE_W-1:0] right_m, logic [GRID_W-1:0] grid,
                                 logic [SCALE_W-1:0] uscale, bit noisy);
        write_reg(CFG_CELL_COUNT, with_junk(CFG_DATA_W'(cells), CNT_W, noisy));
        write_reg(CFG_SMOOTHING, with_junk(CFG_DATA_W'(smooth), 1, noisy));
        write_reg(CFG_LEFT_EDGE, with_junk(CFG_DATA_W'(left_m), MODE_W, noisy));
        write_reg(CFG_RIGHT_EDGE, with_junk(CFG_DATA_W'(right_m), MODE_W, noisy));
        write_reg(CFG_GRID_KIND, with_junk(CFG_DATA_W'(grid), GRID_W, noisy));
        write_reg(CFG_UNIFORM_SCALE, CFG_DATA_W'(uscale));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_pushed || fields_due.size() != 0) @(posedge aclk);
        // a trailing load may still be in flight
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    // Sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_word(cur_word);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (outgoing.size() != 0) begin
                    next_word = outgoing.pop_front();
                    cur_word <= next_word;
                    s_valid  <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern follows bits 9:7 of a free-running cycle counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= '0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                case (rx_cycle[9:7])
                    3'd0, 3'd1: m_ready <= 1'b1;
                    3'd2:       m_ready <= ($urandom_range(0, 1) != 0);
                    3'd3:       m_ready <= ($urandom_range(0, 3) == 0);
                    3'd4:       m_ready <= (rx_cycle[2:0] != 3'd0);
                    default:    m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fields_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected field word: value %0d saturated %0b",
                             m_field_value, m_saturated);
                errors++;
            end else begin
                want = fields_due.pop_front();
                if (m_field_value !== want.value || m_saturated !== want.clipped) begin
                    if (errors < 10)
                        $display("field mismatch: expected %0d sat %0b, got %0d sat %0b",
                                 want.value, want.clipped, m_field_value, m_saturated);
                    errors++;
                end
            end
        end
    end

    // Hold off results long enough for the block to back up into its input
    initial begin
        wait (phase_no == 5);
        repeat (20) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int count_val;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // register values straight from reset
        push_load(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        push_load(1, 32'h80000000, 32'h80000000, 32'h00000000);
        push_load(2, 32'h00000000, 32'hFFFFFFFF, 32'h00010000);
        push_load(3, 32'h00018000, 32'hFFFF0000, 32'h00008000);
        push_load(1023, 32'h00010000, 32'h00020000, 32'h00048000);
        push_load(1024, 32'hFFFE0000, 32'h00000001, 32'hFFFFFFFF);
        push_load(TOP_POS, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
        push_read(0);
        push_read(1);
        push_read(2);
        push_read(1023);
        push_read(1024);
        push_read(TOP_POS);
        wait_idle();

        set_registers(3, 1'b1, EDGE_ZERO, EDGE_REFLECT, GRID_CELL, '0, 1'b0);
        push_read(0);
        push_read(1);
        push_read(2);
        push_read(3);
        wait_idle();

        // cell count below the minimum, spare edge and grid codes
        set_registers(0, 1'b1, EDGE_PERIODIC, EDGE_ALT_WRAP, GRID_ALT_NONE, '1, 1'b1);
        push_read(0);
        push_read(2);
        wait_idle();

        set_registers(3, 1'b0, EDGE_PERIODIC, EDGE_ALT_WRAP, GRID_UNIFORM, '1, 1'b0);
        push_read(1);
        push_read(2);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            phase_no = ph;
            case (ph)
                0:       count_val = 3;
                1:       count_val = TOP_POS;
                2:       count_val = CELLS;
                3:       count_val = 1;
                4:       count_val = 0;
                default: count_val = ($urandom_range(0, 7) == 0) ? $urandom_range(3, CELLS)
                                                                 : $urandom_range(3, 40);
            endcase
            set_registers(count_val, ph % 3 != 2, MODE_W'(ph % 4), MODE_W'($urandom_range(0, 3)),
                          GRID_W'($urandom_range(0, 3)), rand_inv_width(),
                          $urandom_range(0, 3) == 0);
            random_phase(ph == 5 ? 100 : 50);
            wait_idle();
        end

        if (fields_due.size() != 0) begin
            $display("%0d field words never arrived", fields_due.size());
            errors += fields_due.size();
        end
        $display("covered %0d loads and %0d reads over %0d register settings",
                 loads_seen, reads_seen, settings_used + 1);
        $display("%0d reads clipped, %0d past the cell count, %0d errors",
                 clipped_seen, beyond_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
